// File: rtl/assert_macros.svh
// assert_macros.svh: assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion with reset gating.
`define TBH_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also holds while in reset.
`define TBH_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tbh_pkg.sv
// tbh_pkg: types and constants for the touch button hit test block.
// No dependencies.
`timescale 1ns / 1ps

package tbh_pkg;

    localparam int COORD_W   = 11;
    localparam int RAW_W     = 10;
    localparam int PRES_W    = 16;
    localparam int CNT_IN_W  = 5;
    localparam int IDX_OUT_W = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_W     = 21;
    localparam int MAG_W     = 20;
    localparam int DEN_W     = 10;
    localparam int STEP_W    = 5;
    localparam logic [STEP_W-1:0] DIV_STEPS = 5'd20;

    localparam logic [PRES_W-1:0] RST_PRESSURE_MIN   = 16'd200;
    localparam logic [PRES_W-1:0] RST_PRESSURE_MAX   = 16'd1000;
    localparam logic [RAW_W-1:0]  RST_HORIZ_RAW_START = 10'd963;
    localparam logic [RAW_W-1:0]  RST_HORIZ_RAW_END   = 10'd201;
    localparam logic [RAW_W-1:0]  RST_VERT_RAW_START  = 10'd928;
    localparam logic [RAW_W-1:0]  RST_VERT_RAW_END    = 10'd188;
    localparam logic [RAW_W-1:0]  RST_SCREEN_WIDTH    = 10'd480;
    localparam logic [RAW_W-1:0]  RST_SCREEN_HEIGHT   = 10'd320;

    localparam logic signed [COORD_W-1:0] PIX_MAX = 11'sd1023;
    localparam logic [MAG_W-1:0] MAG_POS_LIMIT = 20'd1023;
    localparam logic [MAG_W-1:0] MAG_NEG_LIMIT = 20'd1024;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_SETCNT = 2'd1,
        ACT_TOUCH  = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESSURE_MIN    = 3'd0,
        REG_PRESSURE_MAX    = 3'd1,
        REG_HORIZ_RAW_START = 3'd2,
        REG_HORIZ_RAW_END   = 3'd3,
        REG_VERT_RAW_START  = 3'd4,
        REG_VERT_RAW_END    = 3'd5,
        REG_SCREEN_WIDTH    = 3'd6,
        REG_SCREEN_HEIGHT   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_SETCNT = 2'd1,
        OP_TOUCH  = 2'd2
    } op_t;

    typedef struct packed {
        logic [PRES_W-1:0] pressure_min;
        logic [PRES_W-1:0] pressure_max;
        logic [RAW_W-1:0]  horiz_raw_start;
        logic [RAW_W-1:0]  horiz_raw_end;
        logic [RAW_W-1:0]  vert_raw_start;
        logic [RAW_W-1:0]  vert_raw_end;
        logic [RAW_W-1:0]  screen_width;
        logic [RAW_W-1:0]  screen_height;
    } cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
    } rect_t;

    typedef struct packed {
        op_t                 op;
        logic                pressed;
        rect_t               rect;
        logic [CNT_IN_W-1:0] new_count;
        logic [RAW_W-1:0]    raw_horiz;
        logic [RAW_W-1:0]    raw_vert;
    } cmd_t;

endpackage

// File: rtl/tbh_cfg.sv
// tbh_cfg: configuration register file for the hit test block.
// Depends on tbh_pkg.
`timescale 1ns / 1ps

module tbh_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tbh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbh_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tbh_pkg::cfg_t                    cfg
);

    tbh_pkg::cfg_t cfg_reg;
    tbh_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                tbh_pkg::REG_PRESSURE_MIN:    cfg_next.pressure_min = cfg_data;
                tbh_pkg::REG_PRESSURE_MAX:    cfg_next.pressure_max = cfg_data;
                tbh_pkg::REG_HORIZ_RAW_START:
                    cfg_next.horiz_raw_start = cfg_data[tbh_pkg::RAW_W-1:0];
                tbh_pkg::REG_HORIZ_RAW_END:
                    cfg_next.horiz_raw_end = cfg_data[tbh_pkg::RAW_W-1:0];
                tbh_pkg::REG_VERT_RAW_START:
                    cfg_next.vert_raw_start = cfg_data[tbh_pkg::RAW_W-1:0];
                tbh_pkg::REG_VERT_RAW_END:
                    cfg_next.vert_raw_end = cfg_data[tbh_pkg::RAW_W-1:0];
                tbh_pkg::REG_SCREEN_WIDTH:
                    cfg_next.screen_width = cfg_data[tbh_pkg::RAW_W-1:0];
                tbh_pkg::REG_SCREEN_HEIGHT:
                    cfg_next.screen_height = cfg_data[tbh_pkg::RAW_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressure_min    <= tbh_pkg::RST_PRESSURE_MIN;
            cfg_reg.pressure_max    <= tbh_pkg::RST_PRESSURE_MAX;
            cfg_reg.horiz_raw_start <= tbh_pkg::RST_HORIZ_RAW_START;
            cfg_reg.horiz_raw_end   <= tbh_pkg::RST_HORIZ_RAW_END;
            cfg_reg.vert_raw_start  <= tbh_pkg::RST_VERT_RAW_START;
            cfg_reg.vert_raw_end    <= tbh_pkg::RST_VERT_RAW_END;
            cfg_reg.screen_width    <= tbh_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height   <= tbh_pkg::RST_SCREEN_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/tbh_front.sv
// tbh_front: accepts requests, decodes the action, qualifies pressure and
// queues commands for the back end. Depends on tbh_pkg.
`timescale 1ns / 1ps

module tbh_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  tbh_pkg::cfg_t                          cfg,
    input  logic                                   start,
    input  logic [1:0]                             action,
    input  logic signed [tbh_pkg::COORD_W-1:0]     rect_left,
    input  logic signed [tbh_pkg::COORD_W-1:0]     rect_top,
    input  logic signed [tbh_pkg::COORD_W-1:0]     rect_right,
    input  logic signed [tbh_pkg::COORD_W-1:0]     rect_bottom,
    input  logic [tbh_pkg::CNT_IN_W-1:0]           new_count,
    input  logic [tbh_pkg::RAW_W-1:0]              raw_horiz,
    input  logic [tbh_pkg::RAW_W-1:0]              raw_vert,
    input  logic [tbh_pkg::PRES_W-1:0]             pressure,
    output logic                                   busy,
    output logic                                   q_valid,
    output tbh_pkg::cmd_t                          q_head,
    input  logic                                   q_pop
);

    tbh_pkg::cmd_t queue_reg [2];
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    tbh_pkg::cmd_t cmd;
    logic          keep;
    logic          push;

    always_comb
    begin
        keep           = 1'b1;
        cmd.op         = tbh_pkg::OP_TOUCH;
        cmd.pressed    = (pressure > cfg.pressure_min) && (pressure < cfg.pressure_max);
        cmd.rect.left   = rect_left;
        cmd.rect.top    = rect_top;
        cmd.rect.right  = rect_right;
        cmd.rect.bottom = rect_bottom;
        cmd.new_count  = new_count;
        cmd.raw_horiz  = raw_horiz;
        cmd.raw_vert   = raw_vert;
        unique case (action)
            tbh_pkg::ACT_APPEND: cmd.op = tbh_pkg::OP_APPEND;
            tbh_pkg::ACT_SETCNT: cmd.op = tbh_pkg::OP_SETCNT;
            tbh_pkg::ACT_TOUCH:  cmd.op = tbh_pkg::OP_TOUCH;
            default:             keep = 1'b0;
        endcase
    end

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy && keep;
    assign q_valid = (count_reg != 2'd0);
    assign q_head  = queue_reg[rd_ptr_reg];

    always_comb
    begin
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

// File: rtl/tbh_div.sv
// tbh_div: signed restoring divider, one quotient bit per cycle, with the
// result truncated toward zero and saturated to 11 bits. Depends on tbh_pkg.
`timescale 1ns / 1ps

module tbh_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [tbh_pkg::NUM_W-1:0]     dividend,
    input  logic signed [tbh_pkg::COORD_W-1:0]   divisor,
    output logic                                 done,
    output logic signed [tbh_pkg::COORD_W-1:0]  quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [tbh_pkg::STEP_W-1:0]        cnt_reg, cnt_next;
    logic [tbh_pkg::DEN_W-1:0]         rem_reg, rem_next;
    logic [tbh_pkg::MAG_W-1:0]         quo_reg, quo_next;
    logic [tbh_pkg::DEN_W-1:0]         den_reg, den_next;
    logic                              neg_reg, neg_next;
    logic signed [tbh_pkg::COORD_W-1:0] q_reg, q_next;
    logic signed [tbh_pkg::NUM_W-1:0]  num_abs;
    logic signed [tbh_pkg::COORD_W-1:0] den_abs;
    logic [tbh_pkg::DEN_W:0]           shifted;
    logic                              ge;
    logic [tbh_pkg::COORD_W:0]         mag12;

    always_comb
    begin
        num_abs   = dividend[tbh_pkg::NUM_W-1] ? -dividend : dividend;
        den_abs   = divisor[tbh_pkg::COORD_W-1] ? -divisor : divisor;
        shifted   = {rem_reg, quo_reg[tbh_pkg::MAG_W-1]};
        ge        = (shifted >= {1'b0, den_reg});
        mag12     = {1'b0, quo_reg[tbh_pkg::COORD_W-1:0]};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;

        if (start)
        begin
            if (divisor == '0)
            begin
                q_next    = '0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = tbh_pkg::DIV_STEPS;
                rem_next  = '0;
                quo_next  = num_abs[tbh_pkg::MAG_W-1:0];
                den_next  = den_abs[tbh_pkg::DEN_W-1:0];
                neg_next  = dividend[tbh_pkg::NUM_W-1] ^ divisor[tbh_pkg::COORD_W-1];
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_next = ge ? (shifted[tbh_pkg::DEN_W-1:0] - den_reg)
                              : shifted[tbh_pkg::DEN_W-1:0];
                quo_next = {quo_reg[tbh_pkg::MAG_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                begin
                    if (quo_reg > tbh_pkg::MAG_NEG_LIMIT)
                        q_next = -tbh_pkg::PIX_MAX - 11'sd1;
                    else
                        q_next = $signed(mag12[tbh_pkg::COORD_W-1:0] ^ '1) + 11'sd1;
                end
                else
                begin
                    if (quo_reg > tbh_pkg::MAG_POS_LIMIT)
                        q_next = tbh_pkg::PIX_MAX;
                    else
                        q_next = $signed(mag12[tbh_pkg::COORD_W-1:0]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/tbh_back.sv
// tbh_back: executes queued commands: rectangle table, live count, axis
// mapping through the shared divider and the rectangle scan.
// Depends on tbh_pkg and tbh_div.
`timescale 1ns / 1ps

module tbh_back #(
    parameter int MAX_BUTTONS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tbh_pkg::cfg_t                        cfg,
    input  logic                                 q_valid,
    input  tbh_pkg::cmd_t                        q_head,
    output logic                                 q_pop,
    output logic                                 result_valid,
    output logic                                 pressed,
    output logic                                 hit,
    output logic [tbh_pkg::IDX_OUT_W-1:0]        button_index,
    output logic signed [tbh_pkg::COORD_W-1:0]  pixel_horiz,
    output logic signed [tbh_pkg::COORD_W-1:0]  pixel_vert
);

    localparam int AW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
    localparam int CW = $clog2(MAX_BUTTONS + 1);
    localparam int NW = (CW > tbh_pkg::CNT_IN_W) ? CW : tbh_pkg::CNT_IN_W;
    localparam int IW = (AW > tbh_pkg::IDX_OUT_W) ? AW : tbh_pkg::IDX_OUT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BUTTONS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIVH = 4'b0010,
        S_DIVV = 4'b0100,
        S_SCAN = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [CW-1:0]                       live_cnt_reg, live_cnt_next;
    logic [CW-1:0]                       scan_idx_reg, scan_idx_next;
    logic                                rd_vld_reg, rd_vld_next;
    logic [AW-1:0]                       rd_idx_reg, rd_idx_next;
    tbh_pkg::rect_t                      rd_data_reg;
    tbh_pkg::rect_t                      store [MAX_BUTTONS];
    logic                                kick_reg, kick_next;
    logic signed [tbh_pkg::NUM_W-1:0]    num_h_reg, num_h_next, num_v_reg, num_v_next;
    logic signed [tbh_pkg::COORD_W-1:0]  span_h_reg, span_h_next, span_v_reg, span_v_next;
    logic signed [tbh_pkg::COORD_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic                                res_valid_reg, res_valid_next;
    logic                                res_pressed_reg, res_pressed_next;
    logic                                res_hit_reg, res_hit_next;
    logic [tbh_pkg::IDX_OUT_W-1:0]       res_idx_reg, res_idx_next;
    logic signed [tbh_pkg::COORD_W-1:0]  res_px_reg, res_px_next, res_py_reg, res_py_next;
    logic                                st_wr_en;
    logic signed [tbh_pkg::COORD_W-1:0]  diff_h, diff_v;
    logic signed [tbh_pkg::NUM_W:0]      prod_h, prod_v;
    logic [NW-1:0]                       nc_ext;
    logic                                issue;
    logic                                contains;
    logic [IW-1:0]                       idx_ext;
    logic                                div_done;
    logic signed [tbh_pkg::COORD_W-1:0]  div_q;
    logic signed [tbh_pkg::NUM_W-1:0]    div_num;
    logic signed [tbh_pkg::COORD_W-1:0]  div_den;

    assign div_num = (state_reg == S_DIVV) ? num_v_reg : num_h_reg;
    assign div_den = (state_reg == S_DIVV) ? span_v_reg : span_h_reg;

    tbh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (kick_reg),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        diff_h = $signed({1'b0, q_head.raw_horiz}) - $signed({1'b0, cfg.horiz_raw_start});
        diff_v = $signed({1'b0, q_head.raw_vert}) - $signed({1'b0, cfg.vert_raw_start});
        prod_h = diff_h * $signed({1'b0, cfg.screen_width});
        prod_v = diff_v * $signed({1'b0, cfg.screen_height});
        nc_ext = NW'(q_head.new_count);
        issue  = (scan_idx_reg < live_cnt_reg);
        contains = rd_vld_reg
                && (px_reg > rd_data_reg.left) && (px_reg < rd_data_reg.right)
                && (py_reg > rd_data_reg.top) && (py_reg < rd_data_reg.bottom);
        idx_ext = IW'(rd_idx_reg);
    end

    always_comb
    begin
        state_next       = state_reg;
        live_cnt_next    = live_cnt_reg;
        scan_idx_next    = scan_idx_reg;
        rd_vld_next      = 1'b0;
        rd_idx_next      = rd_idx_reg;
        kick_next        = 1'b0;
        num_h_next       = num_h_reg;
        num_v_next       = num_v_reg;
        span_h_next      = span_h_reg;
        span_v_next      = span_v_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        res_valid_next   = 1'b0;
        res_pressed_next = res_pressed_reg;
        res_hit_next     = res_hit_reg;
        res_idx_next     = res_idx_reg;
        res_px_next      = res_px_reg;
        res_py_next      = res_py_reg;
        q_pop            = 1'b0;
        st_wr_en         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_head.op)
                        tbh_pkg::OP_APPEND:
                        begin
                            if (live_cnt_reg < MAX_CNT)
                            begin
                                st_wr_en      = 1'b1;
                                live_cnt_next = live_cnt_reg + 1'b1;
                            end
                        end
                        tbh_pkg::OP_SETCNT:
                        begin
                            live_cnt_next = (nc_ext > NW'(MAX_BUTTONS)) ? MAX_CNT
                                                                        : nc_ext[CW-1:0];
                        end
                        tbh_pkg::OP_TOUCH:
                        begin
                            if (q_head.pressed)
                            begin
                                num_h_next  = prod_h[tbh_pkg::NUM_W-1:0];
                                num_v_next  = prod_v[tbh_pkg::NUM_W-1:0];
                                span_h_next = $signed({1'b0, cfg.horiz_raw_end})
                                            - $signed({1'b0, cfg.horiz_raw_start});
                                span_v_next = $signed({1'b0, cfg.vert_raw_end})
                                            - $signed({1'b0, cfg.vert_raw_start});
                                kick_next   = 1'b1;
                                state_next  = S_DIVH;
                            end
                            else
                            begin
                                res_valid_next   = 1'b1;
                                res_pressed_next = 1'b0;
                                res_hit_next     = 1'b0;
                                res_idx_next     = '0;
                                res_px_next      = '0;
                                res_py_next      = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIVH:
            begin
                if (div_done)
                begin
                    px_next    = div_q;
                    kick_next  = 1'b1;
                    state_next = S_DIVV;
                end
            end
            S_DIVV:
            begin
                if (div_done)
                begin
                    py_next       = div_q;
                    scan_idx_next = '0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (contains)
                begin
                    res_valid_next   = 1'b1;
                    res_pressed_next = 1'b1;
                    res_hit_next     = 1'b1;
                    res_idx_next     = idx_ext[tbh_pkg::IDX_OUT_W-1:0];
                    res_px_next      = px_reg;
                    res_py_next      = py_reg;
                    state_next       = S_IDLE;
                end
                else if (!issue && !rd_vld_reg)
                begin
                    res_valid_next   = 1'b1;
                    res_pressed_next = 1'b1;
                    res_hit_next     = 1'b0;
                    res_idx_next     = '0;
                    res_px_next      = px_reg;
                    res_py_next      = py_reg;
                    state_next       = S_IDLE;
                end
                else if (issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = scan_idx_reg[AW-1:0];
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            kick_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_cnt_reg  <= live_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            kick_reg      <= kick_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg    <= scan_idx_next;
        rd_idx_reg      <= rd_idx_next;
        num_h_reg       <= num_h_next;
        num_v_reg       <= num_v_next;
        span_h_reg      <= span_h_next;
        span_v_reg      <= span_v_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        res_pressed_reg <= res_pressed_next;
        res_hit_reg     <= res_hit_next;
        res_idx_reg     <= res_idx_next;
        res_px_reg      <= res_px_next;
        res_py_reg      <= res_py_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_wr_en)
        begin
            store[live_cnt_reg[AW-1:0]] <= q_head.rect;
        end
        rd_data_reg <= store[scan_idx_reg[AW-1:0]];
    end

    assign result_valid = res_valid_reg;
    assign pressed      = res_pressed_reg;
    assign hit          = res_hit_reg;
    assign button_index = res_idx_reg;
    assign pixel_horiz  = res_px_reg;
    assign pixel_vert   = res_py_reg;

endmodule

// File: rtl/touch_button_hit_test.sv
// touch_button_hit_test: top level of the touch button hit test block.
// Depends on tbh_pkg, tbh_cfg, tbh_front and tbh_back.
//
// Usage:
//   Requests enter on start while busy is low; action selects append
//   rectangle, set live count or touch sample. Action code three is taken
//   and dropped. A two-entry command queue parts the front end from the
//   execution side, so busy rises only when that queue is full.
//   Only touch requests return a result: result_valid is high for one
//   cycle with pressed, hit, button_index, pixel_horiz and pixel_vert.
//   The receiver cannot stall; every result must be taken when shown.
//   The back end carries out append and set count from its idle state. A
//   touch outside the pressure window gives its result through the command
//   queue and the result registers; a pressed touch runs two 20-step
//   divisions on the one shared divider and then a scan reading one table
//   entry per cycle over the N live rectangles (N at most MAX_BUTTONS),
//   which stops at the first hit, entry K, or reports a miss when all are read.
//   Configuration writes via cfg_wr_en, cfg_index and cfg_data, while idle.
//   Reset empties the queue, clears the live count and loads register
//   defaults; the rectangle table holds no value until written.
`timescale 1ns / 1ps

module touch_button_hit_test #(
    parameter int MAX_BUTTONS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           action,
    input  logic signed [tbh_pkg::COORD_W-1:0]   rect_left,
    input  logic signed [tbh_pkg::COORD_W-1:0]   rect_top,
    input  logic signed [tbh_pkg::COORD_W-1:0]   rect_right,
    input  logic signed [tbh_pkg::COORD_W-1:0]   rect_bottom,
    input  logic [tbh_pkg::CNT_IN_W-1:0]         new_count,
    input  logic [tbh_pkg::RAW_W-1:0]            raw_horiz,
    input  logic [tbh_pkg::RAW_W-1:0]            raw_vert,
    input  logic [tbh_pkg::PRES_W-1:0]           pressure,
    input  logic                                 cfg_wr_en,
    input  logic [tbh_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tbh_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 result_valid,
    output logic                                 pressed,
    output logic                                 hit,
    output logic [tbh_pkg::IDX_OUT_W-1:0]        button_index,
    output logic signed [tbh_pkg::COORD_W-1:0]  pixel_horiz,
    output logic signed [tbh_pkg::COORD_W-1:0]  pixel_vert
);

    tbh_pkg::cfg_t cfg;
    tbh_pkg::cmd_t q_head;
    logic          q_valid;
    logic          q_pop;

    tbh_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbh_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .start       (start),
        .action      (action),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_right  (rect_right),
        .rect_bottom (rect_bottom),
        .new_count   (new_count),
        .raw_horiz   (raw_horiz),
        .raw_vert    (raw_vert),
        .pressure    (pressure),
        .busy        (busy),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop)
    );

    tbh_back #(
        .MAX_BUTTONS (MAX_BUTTONS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .pressed      (pressed),
        .hit          (hit),
        .button_index (button_index),
        .pixel_horiz  (pixel_horiz),
        .pixel_vert   (pixel_vert)
    );

endmodule

// File: rtl/tbh_checker.sv
// tbh_checker: port-level checks for touch_button_hit_test, bound to the top.
// Depends on tbh_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbh_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 result_valid,
    input logic                                 pressed,
    input logic                                 hit,
    input logic [tbh_pkg::IDX_OUT_W-1:0]        button_index,
    input logic signed [tbh_pkg::COORD_W-1:0]   pixel_horiz,
    input logic signed [tbh_pkg::COORD_W-1:0]   pixel_vert
);

    logic touch_cleared;

    assign touch_cleared = !hit && (button_index == '0) && (pixel_horiz == '0)
                        && (pixel_vert == '0);

    `TBH_ASSERT(a_idle_touch_zero, clk, rst_n,
        result_valid && !pressed |-> touch_cleared, "unpressed touch result not cleared")
    `TBH_ASSERT(a_miss_index_zero, clk, rst_n,
        result_valid && !hit |-> button_index == '0, "miss with nonzero index")
    `TBH_ASSERT(a_busy_after_request, clk, rst_n,
        $rose(busy) |-> $past(start && !busy), "busy rose without a request")
    `TBH_ASSERT_ALWAYS(a_reset_no_result, clk,
        !rst_n |=> !result_valid && !busy, "activity right after reset")

endmodule

bind touch_button_hit_test tbh_checker u_tbh_checker (.*);

// File: test/tb_touch_button_hit_test.sv
// tb_touch_button_hit_test: self-checking bench for touch_button_hit_test.
// Directed and random requests against an in-bench model of the button table,
// pressure window and axis calibration. Depends on tbh_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_touch_button_hit_test;

    localparam int          COORD_W       = tbh_pkg::COORD_W;
    localparam int          RAW_W         = tbh_pkg::RAW_W;
    localparam int          PRES_W        = tbh_pkg::PRES_W;
    localparam int          CNT_IN_W      = tbh_pkg::CNT_IN_W;
    localparam int          IDX_OUT_W     = tbh_pkg::IDX_OUT_W;
    localparam int          CFG_IDX_W     = tbh_pkg::CFG_IDX_W;
    localparam int          CFG_DATA_W    = tbh_pkg::CFG_DATA_W;
    localparam int          MAX_ROWS      = 16;
    localparam int          PHASE_ITEMS   = 67;
    localparam int          SETTLE_CYCLES = 80;
    localparam int          CYCLE_LIMIT   = 600000;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        tbh_pkg::rect_t      rect;
        logic [CNT_IN_W-1:0] new_count;
        logic [RAW_W-1:0]    raw_h;
        logic [RAW_W-1:0]    raw_v;
        logic [PRES_W-1:0]   pressure;
    } panel_req_t;

    typedef struct packed {
        logic                       pressed;
        logic                       hit;
        logic [IDX_OUT_W-1:0]       button;
        logic signed [COORD_W-1:0]  pixel_h;
        logic signed [COORD_W-1:0]  pixel_v;
    } hit_report_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 action;
    logic signed [COORD_W-1:0]  rect_left;
    logic signed [COORD_W-1:0]  rect_top;
    logic signed [COORD_W-1:0]  rect_right;
    logic signed [COORD_W-1:0]  rect_bottom;
    logic [CNT_IN_W-1:0]        new_count;
    logic [RAW_W-1:0]           raw_horiz;
    logic [RAW_W-1:0]           raw_vert;
    logic [PRES_W-1:0]          pressure;
    logic                       cfg_wr_en;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       result_valid;
    logic                       pressed;
    logic                       hit;
    logic [IDX_OUT_W-1:0]       button_index;
    logic signed [COORD_W-1:0]  pixel_horiz;
    logic signed [COORD_W-1:0]  pixel_vert;

    // model state
    tbh_pkg::rect_t rect_model [MAX_ROWS];
    int             table_rows;
    int             rows_written;
    tbh_pkg::cfg_t  cfg_model;
    hit_report_t    pending_reports [$];

    int          mismatches;
    int          requests_sent;
    int          touches_checked;
    int          settings_loaded;
    int          cycle_count;
    bit          steady;

    hit_report_t due_report;
    hit_report_t seen_report;

    touch_button_hit_test #(
        .MAX_BUTTONS (MAX_ROWS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .rect_left    (rect_left),
        .rect_top     (rect_top),
        .rect_right   (rect_right),
        .rect_bottom  (rect_bottom),
        .new_count    (new_count),
        .raw_horiz    (raw_horiz),
        .raw_vert     (raw_vert),
        .pressure     (pressure),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .pressed      (pressed),
        .hit          (hit),
        .button_index (button_index),
        .pixel_horiz  (pixel_horiz),
        .pixel_vert   (pixel_vert)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // raw reading to pixel, truncated toward zero, saturated to 11 bits
    function automatic int calibrate_axis(input int raw, input int first, input int last,
                                          input int size);
        int span;
        int q;
        span = last - first;
        if (span == 0)
            return 0;
        q = ((raw - first) * size) / span;
        if (q > 1023)
            q = 1023;
        if (q < -1024)
            q = -1024;
        return q;
    endfunction

    function automatic void apply_panel_request(input panel_req_t r);
        hit_report_t rep;
        int          px;
        int          py;
        int          l;
        int          t;
        int          rr;
        int          b;
        rep = '0;
        case (r.action)
            tbh_pkg::ACT_APPEND:
            begin
                if (table_rows < MAX_ROWS)
                begin
                    rect_model[table_rows] = r.rect;
                    table_rows++;
                    if (table_rows > rows_written)
                        rows_written = table_rows;
                end
            end
            tbh_pkg::ACT_SETCNT:
            begin
                table_rows = (r.new_count > MAX_ROWS) ? MAX_ROWS : int'(r.new_count);
            end
            tbh_pkg::ACT_TOUCH:
            begin
                rep.pressed = (r.pressure > cfg_model.pressure_min) &&
                              (r.pressure < cfg_model.pressure_max);
                if (rep.pressed)
                begin
                    px = calibrate_axis(r.raw_h, cfg_model.horiz_raw_start,
                                        cfg_model.horiz_raw_end, cfg_model.screen_width);
                    py = calibrate_axis(r.raw_v, cfg_model.vert_raw_start,
                                        cfg_model.vert_raw_end, cfg_model.screen_height);
                    rep.pixel_h = px[COORD_W-1:0];
                    rep.pixel_v = py[COORD_W-1:0];
                    for (int i = 0; i < table_rows; i++)
                    begin
                        l  = $signed(rect_model[i].left);
                        t  = $signed(rect_model[i].top);
                        rr = $signed(rect_model[i].right);
                        b  = $signed(rect_model[i].bottom);
                        if (!rep.hit && px > l && px < rr && py > t && py < b)
                        begin
                            rep.hit    = 1'b1;
                            rep.button = i[IDX_OUT_W-1:0];
                        end
                    end
                end
                pending_reports.push_back(rep);
            end
            default: ;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input hit_report_t want,
                                 input hit_report_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("MISMATCH %s @%0t: expected p=%0b h=%0b idx=%0d x=%0d y=%0d",
                     what, $realtime, want.pressed, want.hit, want.button, want.pixel_h,
                     want.pixel_v);
            $display("MISMATCH %s @%0t: got      p=%0b h=%0b idx=%0d x=%0d y=%0d",
                     what, $realtime, got.pressed, got.hit, got.button, got.pixel_h,
                     got.pixel_v);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            seen_report = '{pressed, hit, button_index, pixel_horiz, pixel_vert};
            if (pending_reports.size() == 0)
            begin
                note_mismatch("unexpected report", '0, seen_report);
            end
            else
            begin
                due_report = pending_reports.pop_front();
                touches_checked++;
                if (seen_report.pressed !== due_report.pressed)
                    note_mismatch("pressed", due_report, seen_report);
                if (seen_report.hit !== due_report.hit)
                    note_mismatch("hit", due_report, seen_report);
                if (seen_report.button !== due_report.button)
                    note_mismatch("button_index", due_report, seen_report);
                if (seen_report.pixel_h !== due_report.pixel_h)
                    note_mismatch("pixel_horiz", due_report, seen_report);
                if (seen_report.pixel_v !== due_report.pixel_v)
                    note_mismatch("pixel_vert", due_report, seen_report);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout: %0d reports still outstanding", pending_reports.size());
        $display("tb_touch_button_hit_test: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int k;
        if (steady)
            return 0;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        if (k < 92)
            return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    task automatic send_request(input panel_req_t r);
        int gap;
        start       <= 1'b1;
        action      <= r.action;
        rect_left   <= r.rect.left;
        rect_top    <= r.rect.top;
        rect_right  <= r.rect.right;
        rect_bottom <= r.rect.bottom;
        new_count   <= r.new_count;
        raw_horiz   <= r.raw_h;
        raw_vert    <= r.raw_v;
        pressure    <= r.pressure;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_panel_request(r);
        requests_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait for all reports, then let trailing appends/set-counts finish
    task automatic settle();
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input tbh_pkg::cfg_t c, input bit fuzz);
        logic [5:0] junk;
        for (int i = 0; i < 8; i++)
        begin
            junk = fuzz ? 6'($urandom_range(0, 63)) : 6'd0;
            cfg_wr_en <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            case (tbh_pkg::cfg_idx_t'(i))
                tbh_pkg::REG_PRESSURE_MIN:    cfg_data <= c.pressure_min;
                tbh_pkg::REG_PRESSURE_MAX:    cfg_data <= c.pressure_max;
                tbh_pkg::REG_HORIZ_RAW_START: cfg_data <= {junk, c.horiz_raw_start};
                tbh_pkg::REG_HORIZ_RAW_END:   cfg_data <= {junk, c.horiz_raw_end};
                tbh_pkg::REG_VERT_RAW_START:  cfg_data <= {junk, c.vert_raw_start};
                tbh_pkg::REG_VERT_RAW_END:    cfg_data <= {junk, c.vert_raw_end};
                tbh_pkg::REG_SCREEN_WIDTH:    cfg_data <= {junk, c.screen_width};
                default:                      cfg_data <= {junk, c.screen_height};
            endcase
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        cfg_model = c;
        settings_loaded++;
    endtask

    function automatic panel_req_t touch_request(input int rh, input int rv, input int p);
        panel_req_t r;
        r          = '0;
        r.action   = tbh_pkg::ACT_TOUCH;
        r.raw_h    = rh[RAW_W-1:0];
        r.raw_v    = rv[RAW_W-1:0];
        r.pressure = p[PRES_W-1:0];
        return r;
    endfunction

    function automatic panel_req_t append_request(input int l, input int t, input int rr,
                                                  input int b);
        panel_req_t r;
        r             = '0;
        r.action      = tbh_pkg::ACT_APPEND;
        r.rect.left   = l[COORD_W-1:0];
        r.rect.top    = t[COORD_W-1:0];
        r.rect.right  = rr[COORD_W-1:0];
        r.rect.bottom = b[COORD_W-1:0];
        return r;
    endfunction

    function automatic panel_req_t append_request_from(input tbh_pkg::rect_t rc);
        return append_request($signed(rc.left), $signed(rc.top), $signed(rc.right),
                              $signed(rc.bottom));
    endfunction

    function automatic panel_req_t count_request(input int n);
        panel_req_t r;
        r           = '0;
        r.action    = tbh_pkg::ACT_SETCNT;
        r.new_count = n[CNT_IN_W-1:0];
        return r;
    endfunction

    function automatic tbh_pkg::rect_t random_rect();
        tbh_pkg::rect_t rc;
        int             x0;
        int             y0;
        int             x1;
        int             y1;
        if ($urandom_range(0, 4) == 0)
        begin
            rc.left   = COORD_W'($urandom);
            rc.top    = COORD_W'($urandom);
            rc.right  = COORD_W'($urandom);
            rc.bottom = COORD_W'($urandom);
        end
        else
        begin
            x0 = int'($urandom_range(0, int'(cfg_model.screen_width) + 40)) - 40;
            y0 = int'($urandom_range(0, int'(cfg_model.screen_height) + 40)) - 40;
            x1 = x0 + int'($urandom_range(1, 400));
            y1 = y0 + int'($urandom_range(1, 400));
            if (x1 > 1023)
                x1 = 1023;
            if (y1 > 1023)
                y1 = 1023;
            rc.left   = x0[COORD_W-1:0];
            rc.top    = y0[COORD_W-1:0];
            rc.right  = x1[COORD_W-1:0];
            rc.bottom = y1[COORD_W-1:0];
        end
        return rc;
    endfunction

    function automatic logic [PRES_W-1:0] pick_pressure();
        int lo;
        int hi;
        int k;
        lo = cfg_model.pressure_min;
        hi = cfg_model.pressure_max;
        k  = $urandom_range(0, 9);
        if (k < 7 && hi > lo + 1)
            return PRES_W'($urandom_range(lo + 1, hi - 1));
        if (k == 7)
            return PRES_W'(lo);
        if (k == 8)
            return PRES_W'(hi);
        return PRES_W'($urandom);
    endfunction

    function automatic panel_req_t random_request();
        panel_req_t r;
        int         k;
        int         n;
        r.rect      = random_rect();
        r.new_count = CNT_IN_W'($urandom);
        r.raw_h     = RAW_W'($urandom);
        r.raw_v     = RAW_W'($urandom);
        r.pressure  = pick_pressure();
        k = $urandom_range(0, 99);
        if (k < 55)
            r.action = tbh_pkg::ACT_TOUCH;
        else if (k < 76)
            r.action = tbh_pkg::ACT_APPEND;
        else if (k < 94)
        begin
            r.action = tbh_pkg::ACT_SETCNT;
            k = $urandom_range(0, 99);
            if (k < 60)
                n = $urandom_range(0, 8);
            else if (k < 85)
                n = $urandom_range(9, 16);
            else
                n = $urandom_range(17, 31);
            // never make an unwritten row live
            if (n > rows_written && rows_written < MAX_ROWS)
                n = rows_written;
            r.new_count = n[CNT_IN_W-1:0];
        end
        else
            r.action = ACT_UNUSED;
        return r;
    endfunction

    function automatic tbh_pkg::cfg_t phase_setting(input int phase);
        tbh_pkg::cfg_t c;
        int            lo;
        c.pressure_min  = 16'd0;
        c.pressure_max  = 16'hFFFF;
        c.screen_width  = 10'd1023;
        c.screen_height = 10'd1023;
        case (phase)
            1:
            begin
                c.horiz_raw_start = 10'd0;
                c.horiz_raw_end   = 10'd1023;
                c.vert_raw_start  = 10'd1023;
                c.vert_raw_end    = 10'd0;
                c.screen_height   = 10'd1;
            end
            2:
            begin
                c.pressure_min    = 16'hFFFF;
                c.pressure_max    = 16'd0;
                c.horiz_raw_start = 10'd512;
                c.horiz_raw_end   = 10'd512;
                c.vert_raw_start  = 10'd0;
                c.vert_raw_end    = 10'd0;
                c.screen_width    = 10'd1;
                c.screen_height   = 10'd1;
            end
            3:
            begin
                c.horiz_raw_start = 10'd0;
                c.horiz_raw_end   = 10'd1;
                c.vert_raw_start  = 10'd1000;
                c.vert_raw_end    = 10'd1001;
            end
            4:
            begin
                c.horiz_raw_start = 10'd1023;
                c.horiz_raw_end   = 10'd1023;
                c.vert_raw_start  = 10'd300;
                c.vert_raw_end    = 10'd300;
            end
            default:
            begin
                lo                = $urandom_range(0, 3000);
                c.pressure_min    = lo[PRES_W-1:0];
                lo                = lo + int'($urandom_range(2, 20000));
                c.pressure_max    = lo[PRES_W-1:0];
                c.horiz_raw_start = RAW_W'($urandom);
                c.horiz_raw_end   = RAW_W'($urandom);
                c.vert_raw_start  = RAW_W'($urandom);
                c.vert_raw_end    = RAW_W'($urandom);
                c.screen_width    = RAW_W'($urandom_range(1, 1023));
                c.screen_height   = RAW_W'($urandom_range(1, 1023));
            end
        endcase
        return c;
    endfunction

    task automatic run_random_phase(input int phase);
        int         sent;
        panel_req_t r;
        if (phase > 0)
        begin
            settle();
            load_config(phase_setting(phase), phase >= 5);
        end
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            if (sent % 16 == 0)
                steady = ($urandom_range(0, 3) == 0);
            r = random_request();
            send_request(r);
            sent++;
        end
        steady = 1'b0;
    endtask

    // pressure window edges at reset calibration, empty table
    task automatic test_default_window();
        send_request(touch_request(582, 558, 200));
        send_request(touch_request(582, 558, 201));
        send_request(touch_request(1023, 0, 1000));
    endtask

    // fill the table, overlap priority, exclusive edges, full append, count clamp
    task automatic test_button_table();
        send_request(append_request(230, 150, 250, 170));
        send_request(append_request(-1024, -1024, 1023, 1023));
        for (int i = 2; i < MAX_ROWS; i++)
            send_request(append_request_from(random_rect()));
        send_request(append_request(0, 0, 5, 5));
        send_request(touch_request(582, 558, 500));
        send_request(touch_request(597, 558, 500));
        send_request(count_request(31));
        send_request(touch_request(201, 188, 999));
        send_request('{ACT_UNUSED, random_rect(), 5'd31, 10'h3FF, 10'h3FF, 16'd500});
        send_request(count_request(0));
        send_request(touch_request(582, 558, 500));
        send_request(count_request(16));
    endtask

    task automatic test_traffic_at_defaults();
        run_random_phase(0);
    endtask

    task automatic test_calibration_extremes();
        for (int p = 1; p <= 4; p++)
            run_random_phase(p);
    endtask

    task automatic test_random_calibration();
        for (int p = 5; p <= 9; p++)
            run_random_phase(p);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        action       = tbh_pkg::ACT_TOUCH;
        rect_left    = '0;
        rect_top     = '0;
        rect_right   = '0;
        rect_bottom  = '0;
        new_count    = '0;
        raw_horiz    = '0;
        raw_vert     = '0;
        pressure     = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches      = 0;
        requests_sent   = 0;
        touches_checked = 0;
        settings_loaded = 0;
        steady          = 1'b0;
        table_rows      = 0;
        rows_written    = 0;
        cfg_model.pressure_min    = tbh_pkg::RST_PRESSURE_MIN;
        cfg_model.pressure_max    = tbh_pkg::RST_PRESSURE_MAX;
        cfg_model.horiz_raw_start = tbh_pkg::RST_HORIZ_RAW_START;
        cfg_model.horiz_raw_end   = tbh_pkg::RST_HORIZ_RAW_END;
        cfg_model.vert_raw_start  = tbh_pkg::RST_VERT_RAW_START;
        cfg_model.vert_raw_end    = tbh_pkg::RST_VERT_RAW_END;
        cfg_model.screen_width    = tbh_pkg::RST_SCREEN_WIDTH;
        cfg_model.screen_height   = tbh_pkg::RST_SCREEN_HEIGHT;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_window();
        test_button_table();
        test_traffic_at_defaults();
        test_calibration_extremes();
        test_random_calibration();
        settle();

        $display("summary: %0d requests sent, %0d touch reports checked, %0d register settings",
                 requests_sent, touches_checked, settings_loaded);
        $display("summary: %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("tb_touch_button_hit_test: done, clean");
        else
            $display("tb_touch_button_hit_test: done, errors");
        $finish;
    end

endmodule
